[src/dmxr_pkg.sv]
// Shared constants, codes and types of the DMX512 receiver slot selector.
`timescale 1ns / 1ps

package dmxr_pkg;

  localparam int FRAME_SLOTS_DEF  = 512;
  localparam int MAX_SELECTED_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int PULSE_W  = 16;
  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 5;
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_TIMEOUT  = 3'd4;

  localparam logic [8:0]  FIRST_CHANNEL_RST = 9'd1;
  localparam logic [4:0]  CHANNEL_COUNT_RST = 5'd6;
  localparam logic [15:0] BREAK_MIN_RST     = 16'd87;
  localparam logic [15:0] BREAK_MAX_RST     = 16'd4600;
  localparam logic [7:0]  MARK_TIMEOUT_RST  = 8'd10;

  localparam logic [BYTE_W-1:0] START_DMX = 8'h00;
  localparam logic [BYTE_W-1:0] START_RDM = 8'hCC;

  localparam logic [KIND_W-1:0] KIND_DMX   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RDM   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

endpackage

[src/dmxr_if.sv]
// Valid/ready channel interfaces for line events and selected slot words.
`timescale 1ns / 1ps

interface dmxr_in_if;
  logic                           valid;
  logic                           ready;
  logic [dmxr_pkg::ACTION_W-1:0]  action;
  logic                           line_level;
  logic [dmxr_pkg::PULSE_W-1:0]   pulse_us;
  logic [dmxr_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, action, line_level, pulse_us, data_byte, input ready);
  modport sink (input valid, action, line_level, pulse_us, data_byte, output ready);
endinterface

interface dmxr_out_if;
  logic                         valid;
  logic                         ready;
  logic [dmxr_pkg::SLOT_W-1:0]  slot_number;
  logic [dmxr_pkg::BYTE_W-1:0]  slot_value;
  logic [dmxr_pkg::KIND_W-1:0]  packet_kind;
  logic                         last_slot;

  modport source (output valid, slot_number, slot_value, packet_kind, last_slot, input ready);
  modport sink (input valid, slot_number, slot_value, packet_kind, last_slot, output ready);
endinterface

[src/dmxr_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module dmxr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/dmx512_receiver_slot_selector_top.sv]
// Top level of the DMX512 receiver: break/mark detector, slot store and slot readout.
//
//   channel | dir | handshake          | word
//   in_ch   | in  | valid/ready        | action, line_level, pulse_us, data_byte
//   out_ch  | out | valid/ready        | slot_number, slot_value, packet_kind, last_slot
//   cfg_*   | in  | cfg_we, no wait    | cfg_index selects register, cfg_data value
//
// Edges, ticks and bytes that do not end a frame leave in_ch.ready high.
// A byte that ends the frame starts a readout that goes, for each emitted slot,
// through a slot store read (ST_RD) and then an output load (ST_LOAD), for up to
// 17 slots by default; the single read port of the slot store sets this order.
// in_ch.ready is low during the readout, which stretches while out_ch stalls. The
// store needs no clearing pass.
// Reset is synchronous; configuration registers return to their defaults.
`timescale 1ns / 1ps

module dmx512_receiver_slot_selector_top #(
  parameter int FRAME_SLOTS  = dmxr_pkg::FRAME_SLOTS_DEF,
  parameter int MAX_SELECTED = dmxr_pkg::MAX_SELECTED_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  dmxr_in_if.sink                           in_ch,
  dmxr_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dmxr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW = $clog2(FRAME_SLOTS);
  localparam logic [dmxr_pkg::INDEX_W:0] FRAME_LIM = (dmxr_pkg::INDEX_W + 1)'(FRAME_SLOTS);
  localparam logic [5:0] MAX_SEL = 6'(MAX_SELECTED);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_BREAK = 3'b010,
    PH_MARK  = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_LOAD = 3'b100
  } rd_state_t;

  logic [8:0]  first_channel_r;
  logic [4:0]  channel_count_r;
  logic [15:0] break_min_r;
  logic [15:0] break_max_r;
  logic [7:0]  mark_timeout_r;

  phase_t                        phase_r, phase_nxt;
  rd_state_t                     state_r, state_nxt;
  logic                          receiving_r, receiving_nxt;
  logic [dmxr_pkg::INDEX_W-1:0]  slot_index_r, slot_index_nxt;
  logic [7:0]                    timeout_r, timeout_nxt;
  logic [dmxr_pkg::SLOT_W-1:0]   sel_r, sel_nxt;
  logic                          oor_r, oor_nxt;
  logic [dmxr_pkg::KIND_W-1:0]   kind_r, kind_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [dmxr_pkg::SLOT_W-1:0]   out_slot_r;
  logic [dmxr_pkg::BYTE_W-1:0]   out_value_r;
  logic [dmxr_pkg::KIND_W-1:0]   out_kind_r;
  logic                          out_last_r;
  logic                          out_load;

  logic                          accept;
  logic                          ram_we;
  logic                          ram_re;
  logic [dmxr_pkg::INDEX_W-1:0]  rd_addr;
  logic [dmxr_pkg::BYTE_W-1:0]   ram_rdata;
  logic [dmxr_pkg::INDEX_W-1:0]  frame_end;
  logic [dmxr_pkg::SLOT_W-1:0]   sel_count;
  logic [dmxr_pkg::KIND_W-1:0]   kind_now;
  logic                          out_free;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign frame_end = dmxr_pkg::INDEX_W'(first_channel_r) + dmxr_pkg::INDEX_W'(channel_count_r);
  assign sel_count = ({1'b0, channel_count_r} > MAX_SEL) ? MAX_SEL[4:0] : channel_count_r;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign ram_we = accept && (in_ch.action == dmxr_pkg::ACT_BYTE) && receiving_r
                  && ({1'b0, slot_index_r} < FRAME_LIM);
  assign ram_re = (state_r == ST_RD);
  assign rd_addr = (sel_r == '0) ? '0
                 : dmxr_pkg::INDEX_W'(first_channel_r) + dmxr_pkg::INDEX_W'(sel_r)
                   - dmxr_pkg::INDEX_W'(1);

  dmxr_ram #(
    .WIDTH (dmxr_pkg::BYTE_W),
    .DEPTH (FRAME_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_index_r[AW-1:0]),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (rd_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (ram_rdata == dmxr_pkg::START_DMX) begin
      kind_now = dmxr_pkg::KIND_DMX;
    end else if (ram_rdata == dmxr_pkg::START_RDM) begin
      kind_now = dmxr_pkg::KIND_RDM;
    end else begin
      kind_now = dmxr_pkg::KIND_OTHER;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    state_nxt      = state_r;
    receiving_nxt  = receiving_r;
    slot_index_nxt = slot_index_r;
    timeout_nxt    = timeout_r;
    sel_nxt        = sel_r;
    oor_nxt        = oor_r;
    kind_nxt       = kind_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (accept) begin
      case (in_ch.action)
        dmxr_pkg::ACT_EDGE: begin
          if (!(receiving_r && timeout_r != '0)) begin
            case (phase_r)
              PH_IDLE: begin
                if (!in_ch.line_level) begin
                  phase_nxt = PH_BREAK;
                end
              end
              PH_BREAK: begin
                if (in_ch.line_level && in_ch.pulse_us > break_min_r
                    && in_ch.pulse_us < break_max_r) begin
                  phase_nxt      = PH_MARK;
                  slot_index_nxt = '0;
                  timeout_nxt    = mark_timeout_r;
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end
              PH_MARK: begin
                receiving_nxt = !in_ch.line_level && (timeout_r != '0);
                phase_nxt     = PH_IDLE;
              end
              default: begin
                phase_nxt = PH_IDLE;
              end
            endcase
          end
        end
        dmxr_pkg::ACT_BYTE: begin
          if (ram_we) begin
            if (slot_index_r >= frame_end) begin
              receiving_nxt  = 1'b0;
              slot_index_nxt = dmxr_pkg::INDEX_W'(1);
              sel_nxt        = '0;
              state_nxt      = ST_RD;
            end else begin
              slot_index_nxt = slot_index_r + dmxr_pkg::INDEX_W'(1);
            end
          end
        end
        dmxr_pkg::ACT_TICK: begin
          if (timeout_r != '0) begin
            timeout_nxt = timeout_r - 8'd1;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
      end
      ST_RD: begin
        oor_nxt   = {1'b0, rd_addr} >= FRAME_LIM;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sel_r == '0) begin
          kind_nxt = kind_now;
        end
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sel_r == sel_count) begin
            state_nxt = ST_IDLE;
          end else begin
            sel_nxt   = sel_r + dmxr_pkg::SLOT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_channel_r <= dmxr_pkg::FIRST_CHANNEL_RST;
      channel_count_r <= dmxr_pkg::CHANNEL_COUNT_RST;
      break_min_r     <= dmxr_pkg::BREAK_MIN_RST;
      break_max_r     <= dmxr_pkg::BREAK_MAX_RST;
      mark_timeout_r  <= dmxr_pkg::MARK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dmxr_pkg::REG_FIRST_CHANNEL: first_channel_r <= cfg_data[8:0];
        dmxr_pkg::REG_CHANNEL_COUNT: channel_count_r <= cfg_data[4:0];
        dmxr_pkg::REG_BREAK_MIN:     break_min_r     <= cfg_data;
        dmxr_pkg::REG_BREAK_MAX:     break_max_r     <= cfg_data;
        dmxr_pkg::REG_MARK_TIMEOUT:  mark_timeout_r  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      state_r      <= ST_IDLE;
      receiving_r  <= 1'b0;
      slot_index_r <= '0;
      timeout_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      state_r      <= state_nxt;
      receiving_r  <= receiving_nxt;
      slot_index_r <= slot_index_nxt;
      timeout_r    <= timeout_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r  <= sel_nxt;
    oor_r  <= oor_nxt;
    kind_r <= kind_nxt;
    if (out_load) begin
      out_slot_r  <= sel_r;
      out_value_r <= oor_r ? '0 : ram_rdata;
      out_kind_r  <= (sel_r == '0) ? kind_now : kind_r;
      out_last_r  <= (sel_r == sel_count);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.slot_number = out_slot_r;
  assign out_ch.slot_value  = out_value_r;
  assign out_ch.packet_kind = out_kind_r;
  assign out_ch.last_slot   = out_last_r;

endmodule
